// ===== design/cosim_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cosim_pkg: shared types and constants for the cosine similarity stream
// Widths of the element, accumulator and count fields, and the request that
// travels from the accumulating front end to the finishing back end.
// ----------------------------------------------------------------------------
package cosim_pkg;
  localparam int ElemWidth = 16;
  localparam int AccWidth  = 48;
  localparam int MaxLen    = 4096;
  localparam int CntWidth  = 13;
  localparam int RootWidth = AccWidth;
  localparam int ProdWidth = 2 * AccWidth;
  localparam int QuotBits  = 15;

  typedef struct packed {
    logic signed [AccWidth-1:0] dot;
    logic [AccWidth-1:0]        norm_a;
    logic [AccWidth-1:0]        norm_b;
    logic [CntWidth-1:0]        count;
    logic                       sat;
  } vec_req_t;

  typedef struct packed {
    logic signed [ElemWidth-1:0] cosine;
    logic signed [AccWidth-1:0]  dot_sum;
    logic                        zero_norm;
    logic                        saturated;
    logic [CntWidth-1:0]         vector_length;
  } vec_res_t;

  // Saturating signed add; the flag reports a clamp.
  function automatic logic [AccWidth:0] sat_add(input logic signed [AccWidth-1:0] a,
                                                input logic signed [AccWidth-1:0] b);
    logic signed [AccWidth:0] s;
    logic [AccWidth-1:0] hi;
    begin
      s  = {a[AccWidth-1], a} + {b[AccWidth-1], b};
      hi = {1'b0, {(AccWidth-1){1'b1}}};
      if (s[AccWidth] != s[AccWidth-1])
        sat_add = s[AccWidth] ? {1'b1, ~hi} : {1'b1, hi};
      else
        sat_add = {1'b0, s[AccWidth-1:0]};
    end
  endfunction
endpackage

// ===== design/cosine_similarity_stream_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cosine_similarity_stream_top: streaming cosine similarity
// Accumulates element pairs and reports dot sum, length and Q1.15 cosine.
// ----------------------------------------------------------------------------
// Input requests arrive on s_axis: tdata carries elem_a then elem_b, tlast
// the last flag. The front end takes one pair per cycle through a product
// register stage and saturating 48-bit sums. A last pair posts a request
// into a two-entry queue; the back end works out the product of the norms,
// the bit-serial square root and the division, and presents the result
// on m_axis until taken. The square root loop dominates the latency
// from the last pair. Pairs of the next vector stream at one a cycle
// meanwhile; the front stalls only if the queue is full, which happens
// when vectors are shorter than the back end time or m_axis stalls. Reset
// clears all sums, the queue and the back end.
// ----------------------------------------------------------------------------
module cosine_similarity_stream_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // elem_a [15:0], elem_b [31:16]
  input  logic        s_axis_tlast,   // last
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata    // cosine, dot_sum, zero_norm, saturated, vector_length, pad
);
  logic f_valid, f_ready, b_valid, b_ready;
  cosim_pkg::vec_req_t f_req, b_req;
  cosim_pkg::vec_res_t res;

  cosim_front u_front (
    .clk(clk), .rst(rst), .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .elem_a(s_axis_tdata[15:0]), .elem_b(s_axis_tdata[31:16]), .last(s_axis_tlast),
    .req_valid(f_valid), .req_ready(f_ready), .req(f_req)
  );
  cosim_queue u_queue (
    .clk(clk), .rst(rst), .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_req),
    .rd_valid(b_valid), .rd_ready(b_ready), .rd_data(b_req)
  );
  cosim_back u_back (
    .clk(clk), .rst(rst), .req_valid(b_valid), .req_ready(b_ready), .req(b_req),
    .res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res(res)
  );

  assign m_axis_tdata = {1'b0, res.vector_length, res.saturated, res.zero_norm,
                         res.dot_sum, res.cosine};
endmodule

// ===== design/cosim_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cosim_front: accumulating front end
// Takes a pair per cycle unless a last pair waits for queue room; a product
// register stage feeds three saturating sums; a last pair pushes a request.
// ----------------------------------------------------------------------------
module cosim_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [cosim_pkg::ElemWidth-1:0] elem_a,
  input  logic signed [cosim_pkg::ElemWidth-1:0] elem_b,
  input  logic                              last,
  output logic                              req_valid,
  input  logic                              req_ready,
  output cosim_pkg::vec_req_t               req
);
  logic signed [2*cosim_pkg::ElemWidth-1:0] p_ab, p_aa, p_bb;
  logic p_valid, p_last;
  logic signed [cosim_pkg::AccWidth-1:0] dot_acc, na_acc, nb_acc;
  logic [cosim_pkg::CntWidth-1:0] pair_count;
  logic sat_seen;
  logic [cosim_pkg::AccWidth:0] s_ab, s_aa, s_bb;
  logic cnt_full, sat_next;
  logic [cosim_pkg::CntWidth-1:0] cnt_next;

  // A final pair in the product stage must wait for queue room.
  assign in_ready = !(p_valid && p_last && !req_ready);
  wire advance = !(p_valid && p_last && !req_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (advance) begin
      p_valid <= in_valid;
    end
    if (advance) begin
      p_ab   <= elem_a * elem_b;
      p_aa   <= elem_a * elem_a;
      p_bb   <= elem_b * elem_b;
      p_last <= last;
    end
  end

  always_comb begin
    s_ab = cosim_pkg::sat_add(dot_acc,
             {{(cosim_pkg::AccWidth-2*cosim_pkg::ElemWidth){p_ab[2*cosim_pkg::ElemWidth-1]}}, p_ab});
    s_aa = cosim_pkg::sat_add(na_acc,
             {{(cosim_pkg::AccWidth-2*cosim_pkg::ElemWidth){p_aa[2*cosim_pkg::ElemWidth-1]}}, p_aa});
    s_bb = cosim_pkg::sat_add(nb_acc,
             {{(cosim_pkg::AccWidth-2*cosim_pkg::ElemWidth){p_bb[2*cosim_pkg::ElemWidth-1]}}, p_bb});
    cnt_full = (pair_count >= cosim_pkg::CntWidth'(cosim_pkg::MaxLen));
    cnt_next = cnt_full ? cosim_pkg::CntWidth'(cosim_pkg::MaxLen) : pair_count + 1'b1;
    sat_next = sat_seen | s_ab[cosim_pkg::AccWidth] | s_aa[cosim_pkg::AccWidth]
             | s_bb[cosim_pkg::AccWidth] | cnt_full;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dot_acc <= '0; na_acc <= '0; nb_acc <= '0; pair_count <= '0; sat_seen <= 1'b0;
    end else if (p_valid && advance) begin
      if (p_last) begin
        dot_acc <= '0; na_acc <= '0; nb_acc <= '0; pair_count <= '0; sat_seen <= 1'b0;
      end else begin
        dot_acc    <= s_ab[cosim_pkg::AccWidth-1:0];
        na_acc     <= s_aa[cosim_pkg::AccWidth-1:0];
        nb_acc     <= s_bb[cosim_pkg::AccWidth-1:0];
        pair_count <= cnt_next;
        sat_seen   <= sat_next;
      end
    end
  end

  assign req_valid  = p_valid && p_last;
  assign req.dot    = s_ab[cosim_pkg::AccWidth-1:0];
  assign req.norm_a = s_aa[cosim_pkg::AccWidth-1:0];
  assign req.norm_b = s_bb[cosim_pkg::AccWidth-1:0];
  assign req.count  = cnt_next;
  assign req.sat    = sat_next;

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    pair_count <= cosim_pkg::CntWidth'(cosim_pkg::MaxLen))
    else $error("pair count beyond limit");
  a_clear: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> pair_count == '0)
    else $error("accumulators not cleared after final pair");
  a_norm_pos: assert property (@(posedge clk) disable iff (rst)
    !na_acc[cosim_pkg::AccWidth-1] && !nb_acc[cosim_pkg::AccWidth-1])
    else $error("norm sum negative");
endmodule

// ===== design/cosim_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cosim_queue: two-entry request queue
// Decouples the front end from the finishing back end.
// ----------------------------------------------------------------------------
module cosim_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr_valid,
  output logic                wr_ready,
  input  cosim_pkg::vec_req_t wr_data,
  output logic                rd_valid,
  input  logic                rd_ready,
  output cosim_pkg::vec_req_t rd_data
);
  cosim_pkg::vec_req_t mem [2];
  logic wp, rp;
  logic [1:0] fill;
  wire do_wr = wr_valid && wr_ready;
  wire do_rd = rd_valid && rd_ready;

  assign wr_ready = (fill != 2'd2);
  assign rd_valid = (fill != 2'd0);
  assign rd_data  = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0; rp <= 1'b0; fill <= 2'd0;
    end else begin
      if (do_wr) wp <= ~wp;
      if (do_rd) rp <= ~rp;
      fill <= fill + {1'b0, do_wr} - {1'b0, do_rd};
    end
    if (do_wr) mem[wp] <= wr_data;
  end

  a_fill: assert property (@(posedge clk) disable iff (rst) fill <= 2'd2)
    else $error("queue fill overflow");
  a_ptr: assert property (@(posedge clk) disable iff (rst)
    (fill == 2'd1) |-> (wp != rp))
    else $error("queue pointers inconsistent");
  a_empty: assert property (@(posedge clk) disable iff (rst)
    (fill == 2'd0) |-> (wp == rp))
    else $error("queue pointers differ when empty");
endmodule

// ===== design/cosim_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cosim_back: finishing back end
// Forms normA*normB over two 24x48 partial-product steps, takes a one-bit
// per cycle floor square root, then a fifteen-step restoring division.
// ----------------------------------------------------------------------------
module cosim_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  cosim_pkg::vec_req_t req,
  output logic                res_valid,
  input  logic                res_ready,
  output cosim_pkg::vec_res_t res
);
  localparam int PW = cosim_pkg::ProdWidth;
  localparam int AW = cosim_pkg::AccWidth;
  localparam int HW = AW / 2;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001, S_MUL = 5'b00010, S_ROOT = 5'b00100,
    S_DIV = 5'b01000, S_OUT = 5'b10000
  } st_t;
  st_t st;

  cosim_pkg::vec_req_t cur;
  logic [PW-1:0] prod, rem;
  logic [AW-1:0] root, mag, r;
  logic [1:0] mstep;
  logic [6:0] bitn;
  logic [3:0] dstep;
  logic [cosim_pkg::QuotBits-1:0] q;
  logic neg, zn;
  logic [HW-1:0] a_half;
  logic [HW+AW-1:0] pp;
  logic [PW+1:0] trial, rem_sub;
  logic [AW:0] r_sh;

  assign req_ready = (st == S_IDLE);
  assign res_valid = (st == S_OUT);

  always_comb begin
    a_half  = mstep[0] ? cur.norm_a[AW-1:HW] : cur.norm_a[HW-1:0];
    pp      = a_half * cur.norm_b;
    // Digit-by-digit root: trial = (4*root + 1) << 2*bit against the remainder.
    trial   = ({2'b0, PW'(root)} << ((bitn << 1) + 7'd2)) | ((PW+2)'(1) << (bitn << 1));
    rem_sub = {2'b0, rem} - trial;
    r_sh    = {r, 1'b0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE;
    end else begin
      case (st)
        S_IDLE: if (req_valid) begin
          cur  <= req;
          zn   <= (req.norm_a == '0) || (req.norm_b == '0);
          neg  <= req.dot[AW-1];
          mag  <= req.dot[AW-1] ? AW'(-req.dot) : req.dot;
          prod <= '0;
          mstep <= 2'd0;
          st   <= S_MUL;
        end
        S_MUL: begin
          prod  <= prod + (PW'(pp) << (mstep[0] ? HW : 0));
          mstep <= mstep + 2'd1;
          if (mstep[0]) begin
            st   <= zn ? S_OUT : S_ROOT;
            rem  <= prod + (PW'(pp) << HW);
            root <= '0;
            bitn <= 7'(AW - 1);
            q    <= '0;
          end
        end
        S_ROOT: begin
          if (!rem_sub[PW+1]) begin
            rem  <= rem_sub[PW-1:0];
            root <= {root[AW-2:0], 1'b1};
          end else begin
            root <= {root[AW-2:0], 1'b0};
          end
          bitn <= bitn - 7'd1;
          if (bitn == 7'd0) begin
            st    <= S_DIV;
            r     <= mag;
            dstep <= 4'd0;
          end
        end
        S_DIV: begin
          if (mag >= root) begin
            q  <= neg ? cosim_pkg::QuotBits'(0) : '1;
            st <= S_OUT;
          end else begin
            if (r_sh >= {1'b0, root}) begin
              r <= AW'(r_sh - {1'b0, root});
              q <= {q[cosim_pkg::QuotBits-2:0], 1'b1};
            end else begin
              r <= r_sh[AW-1:0];
              q <= {q[cosim_pkg::QuotBits-2:0], 1'b0};
            end
            dstep <= dstep + 4'd1;
            if (dstep == 4'(cosim_pkg::QuotBits - 1)) st <= S_OUT;
          end
        end
        S_OUT: if (res_ready) st <= S_IDLE;
        default: st <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    if (zn)
      res.cosine = '0;
    else if (mag >= root)
      res.cosine = neg ? {1'b1, {(cosim_pkg::ElemWidth-1){1'b0}}}
                       : {1'b0, {(cosim_pkg::ElemWidth-1){1'b1}}};
    else
      res.cosine = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
    res.dot_sum       = cur.dot;
    res.zero_norm     = zn;
    res.saturated     = cur.sat;
    res.vector_length = cur.count;
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res))
    else $error("result changed while stalled");
  a_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && zn |-> res.cosine == '0)
    else $error("zero norm with nonzero cosine");
  a_take: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> st == S_MUL)
    else $error("request not started");
endmodule

// ===== tb/sv/cosine_similarity_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cosine_similarity_checker: predicts and checks cosine similarity results
// Watches both stream channels, keeps its own running sums of the dot
// product and the squared norms, and on each last pair works out the result
// expected on m_axis. Each result taken is compared field by field.
// ----------------------------------------------------------------------------
module cosine_similarity_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,
  input  logic        s_axis_tlast,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [79:0] m_axis_tdata,
  output int          fail_count,
  output int          pending_results
);
  localparam logic signed [cosim_pkg::AccWidth-1:0] AccMax =
    {1'b0, {(cosim_pkg::AccWidth-1){1'b1}}};
  localparam logic signed [cosim_pkg::AccWidth-1:0] AccMin =
    {1'b1, {(cosim_pkg::AccWidth-1){1'b0}}};

  logic signed [cosim_pkg::AccWidth-1:0] dot_run, norm_a_run, norm_b_run;
  logic [cosim_pkg::CntWidth-1:0]        pairs_seen;
  logic                                  clamp_seen;
  cosim_pkg::vec_res_t                   expected_results[$];

  function automatic logic signed [cosim_pkg::AccWidth-1:0] clamp_sum(
      input logic signed [cosim_pkg::AccWidth-1:0] acc, input logic signed [31:0] term);
    logic signed [cosim_pkg::AccWidth:0] s;
    begin
      s = $signed({acc[cosim_pkg::AccWidth-1], acc}) + $signed(term);
      if (s > $signed({AccMax[cosim_pkg::AccWidth-1], AccMax})) begin
        clamp_seen = 1'b1;
        clamp_sum = AccMax;
      end else if (s < $signed({AccMin[cosim_pkg::AccWidth-1], AccMin})) begin
        clamp_seen = 1'b1;
        clamp_sum = AccMin;
      end else begin
        clamp_sum = s[cosim_pkg::AccWidth-1:0];
      end
    end
  endfunction

  // Cosine from the finished sums: exact floor root of the norm product,
  // then a restoring division giving fifteen fraction bits.
  function automatic logic signed [cosim_pkg::ElemWidth-1:0] cosine_of(
      input logic signed [cosim_pkg::AccWidth-1:0] dot,
      input logic [cosim_pkg::AccWidth-1:0] na,
      input logic [cosim_pkg::AccWidth-1:0] nb);
    logic [cosim_pkg::ProdWidth-1:0] prod, sq;
    logic [cosim_pkg::AccWidth-1:0]  root, cand;
    logic [63:0]                     mag, rem;
    logic [15:0]                     quot;
    logic                            neg;
    begin
      prod = {{cosim_pkg::AccWidth{1'b0}}, na} * {{cosim_pkg::AccWidth{1'b0}}, nb};
      root = '0;
      for (int i = cosim_pkg::AccWidth - 1; i >= 0; i--) begin
        cand = root | (cosim_pkg::AccWidth'(1) << i);
        sq = {{cosim_pkg::AccWidth{1'b0}}, cand} * {{cosim_pkg::AccWidth{1'b0}}, cand};
        if (sq <= prod) root = cand;
      end
      neg = dot[cosim_pkg::AccWidth-1];
      mag = neg ? 64'(-$signed({{16{dot[cosim_pkg::AccWidth-1]}}, dot})) : 64'(dot);
      if (mag >= 64'(root)) begin
        cosine_of = neg ? -16'sd32768 : 16'sd32767;
      end else begin
        rem = mag;
        quot = '0;
        for (int i = 0; i < cosim_pkg::QuotBits; i++) begin
          rem = rem << 1;
          quot = quot << 1;
          if (rem >= 64'(root)) begin
            rem = rem - 64'(root);
            quot[0] = 1'b1;
          end
        end
        cosine_of = neg ? -$signed(quot) : $signed(quot);
      end
    end
  endfunction

  always @(posedge clk) begin
    cosim_pkg::vec_res_t exp_res, got;
    logic signed [cosim_pkg::ElemWidth-1:0] ea, eb;
    if (rst) begin
      dot_run = '0; norm_a_run = '0; norm_b_run = '0;
      pairs_seen = '0; clamp_seen = 1'b0;
      expected_results.delete();
      fail_count <= 0;
      pending_results <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        ea = s_axis_tdata[15:0];
        eb = s_axis_tdata[31:16];
        dot_run    = clamp_sum(dot_run, ea * eb);
        norm_a_run = clamp_sum(norm_a_run, ea * ea);
        norm_b_run = clamp_sum(norm_b_run, eb * eb);
        if (pairs_seen >= cosim_pkg::CntWidth'(cosim_pkg::MaxLen)) begin
          pairs_seen = cosim_pkg::CntWidth'(cosim_pkg::MaxLen);
          clamp_seen = 1'b1;
        end else begin
          pairs_seen = pairs_seen + 1'b1;
        end
        if (s_axis_tlast) begin
          exp_res.zero_norm = (norm_a_run <= 0) || (norm_b_run <= 0);
          exp_res.cosine = exp_res.zero_norm ? '0 :
                           cosine_of(dot_run, norm_a_run, norm_b_run);
          exp_res.dot_sum = dot_run;
          exp_res.saturated = clamp_seen;
          exp_res.vector_length = pairs_seen;
          expected_results.push_back(exp_res);
          dot_run = '0; norm_a_run = '0; norm_b_run = '0;
          pairs_seen = '0; clamp_seen = 1'b0;
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.cosine        = m_axis_tdata[15:0];
        got.dot_sum       = m_axis_tdata[63:16];
        got.zero_norm     = m_axis_tdata[64];
        got.saturated     = m_axis_tdata[65];
        got.vector_length = m_axis_tdata[78:66];
        if (expected_results.size() == 0) begin
          $error("result with none expected: cosine %0d", $signed(got.cosine));
          fail_count <= fail_count + 1;
        end else begin
          exp_res = expected_results.pop_front();
          if (got.cosine !== exp_res.cosine)
            $error("cosine: expected %0d, got %0d", exp_res.cosine, got.cosine);
          if (got.dot_sum !== exp_res.dot_sum)
            $error("dot_sum: expected %0d, got %0d", exp_res.dot_sum, got.dot_sum);
          if (got.zero_norm !== exp_res.zero_norm)
            $error("zero_norm: expected %0d, got %0d", exp_res.zero_norm, got.zero_norm);
          if (got.saturated !== exp_res.saturated)
            $error("saturated: expected %0d, got %0d", exp_res.saturated, got.saturated);
          if (got.vector_length !== exp_res.vector_length)
            $error("vector_length: expected %0d, got %0d",
                   exp_res.vector_length, got.vector_length);
          if (got !== exp_res) fail_count <= fail_count + 1;
        end
      end
      pending_results <= expected_results.size();
    end
  end
endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the cosine similarity stream
// Sends directed vectors (extremes, zero norms, short runs) and then
// random vectors under three patterns of source gaps and sink back-pressure;
// the checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;   // elem_a [15:0], elem_b [31:16]
  logic        s_axis_tlast = 1'b0; // last
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [79:0] m_axis_tdata;        // cosine, dot_sum, zero_norm, saturated, vector_length
  int          fail_count, pending_results;
  int          send_gap_pct = 0, sink_stall_pct = 0;
  int          quiet_cycles = 0;

  localparam int WatchdogLimit = 20000;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  cosine_similarity_stream_top dut (.*);

  cosine_similarity_checker checker_i (.*);

  always @(posedge clk)
    m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || rst)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic send_pair(input logic [15:0] ea, input logic [15:0] eb, input logic lst);
    if ($urandom_range(99) < send_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {eb, ea};
    s_axis_tlast  <= lst;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  function automatic logic [15:0] rand_elem();
    case ($urandom_range(9))
      0: rand_elem = 16'h8000;
      1: rand_elem = 16'h7FFF;
      2: rand_elem = '0;
      default: rand_elem = 16'($urandom);
    endcase
  endfunction

  // A random vector; now and then one side is all zeros.
  task automatic send_vector(input int len);
    int zero_side;
    logic [15:0] ea, eb;
    zero_side = $urandom_range(11);
    for (int i = 0; i < len; i++) begin
      ea = (zero_side == 0) ? '0 : rand_elem();
      eb = (zero_side == 1) ? '0 : rand_elem();
      send_pair(ea, eb, i == len - 1);
    end
  endtask

  initial begin
    int sent;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_pair(16'h8000, 16'h8000, 1'b1);
    send_pair(16'h8000, 16'h7FFF, 1'b1);
    send_pair(16'h7FFF, 16'h7FFF, 1'b1);
    send_pair(16'h0000, 16'h1234, 1'b1);
    send_pair(16'h4321, 16'h0000, 1'b1);
    send_pair(16'h0000, 16'h0000, 1'b1);
    send_pair(16'h0001, 16'hFFFF, 1'b0);
    send_pair(16'h0002, 16'h0003, 1'b1);
    send_pair(16'h5555, 16'hAAAA, 1'b0);
    send_pair(16'hAAAA, 16'h5555, 1'b0);
    send_pair(16'h7FFF, 16'h8001, 1'b1);
    send_pair(16'h0100, 16'h0001, 1'b0);
    send_pair(16'h0001, 16'h0100, 1'b1);

    sent = 0;
    for (int phase = 0; phase < 3; phase++) begin
      send_gap_pct   = (phase == 0) ? 10 : (phase == 1) ? 53 : 0;
      sink_stall_pct = (phase == 0) ? 53 : (phase == 1) ? 10 : 0;
      while (sent < (phase + 1) * 279) begin
        int len;
        len = ($urandom_range(9) == 0) ? $urandom_range(60, 21) : $urandom_range(12, 1);
        send_vector(len);
        sent += len;
      end
    end
    s_axis_tvalid <= 1'b0;
    s_axis_tlast  <= 1'b0;

    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end
endmodule
